@@ rtl/assert_macros.svh @@
// Assertion helpers used by the duty calculator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define SVPWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks an implication from one cycle to the next, outside of reset.
`define SVPWM_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

@@ rtl/svpwm_pkg.sv @@
package svpwm_pkg;

  // Fixed point constants.
  localparam logic [16:0] SQRT3_Q16 = 17'd113512;

  // Field widths.
  localparam int UW  = 35;  // signed projection width (2^-25 volt)
  localparam int MW  = 34;  // projection magnitude width
  localparam int TW  = 28;  // active time width, quarter ticks
  localparam int SUW = 29;  // width of t1 + t2
  localparam int LW  = 18;  // width of 4 * period_ticks
  localparam int NW  = TW + LW;
  localparam int ONW = 20;  // on-time width

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TIME_GAIN    = 2'd0,
    REG_PERIOD_TICKS = 2'd1,
    REG_TIMER_PERIOD = 2'd2,
    REG_DUTY_CAP     = 2'd3
  } reg_idx_t;

  // Reset values of the registers.
  localparam logic [31:0] TIME_GAIN_RST    = 32'd65536;
  localparam logic [15:0] PERIOD_TICKS_RST = 16'd8400;
  localparam logic [15:0] TIMER_PERIOD_RST = 16'd8400;
  localparam logic [15:0] DUTY_CAP_RST     = 16'd8000;

  // Sector codes from the signs of the projections.
  localparam logic [2:0] SECTOR_0 = 3'd0;
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;
  localparam logic [2:0] SECTOR_6 = 3'd6;
  localparam logic [2:0] SECTOR_7 = 3'd7;

endpackage

@@ rtl/svpwm_cmd_if.sv @@
interface svpwm_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] v_alpha;
  logic signed [15:0] v_beta;

  modport source (output valid, output v_alpha, output v_beta, input ready);
  modport sink (input valid, input v_alpha, input v_beta, output ready);
endinterface

@@ rtl/svpwm_duty_if.sv @@
interface svpwm_duty_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty_a;
  logic [15:0] duty_b;
  logic [15:0] duty_c;
  logic [2:0]  sector;

  modport source (output valid, output duty_a, output duty_b, output duty_c,
                  output sector, input ready);
  modport sink (input valid, input duty_a, input duty_b, input duty_c,
                input sector, output ready);
endinterface

@@ rtl/svpwm_div.sv @@
// Pipelined restoring divider: two numerators over one shared divisor,
// one quotient bit per stage. The quotient must fit in QW bits.
module svpwm_div #(
  parameter int NW = 46,
  parameter int DW = 29,
  parameter int QW = 18,
  parameter int SW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] n1,
  input  logic [NW-1:0] n2,
  input  logic [DW-1:0] d,
  input  logic [SW-1:0] side_i,
  output logic          out_vld,
  output logic [QW-1:0] q1,
  output logic [QW-1:0] q2,
  output logic [SW-1:0] side_o
);

  logic          vld_r [QW];
  logic [DW-1:0] r1_r  [QW];
  logic [DW-1:0] r2_r  [QW];
  logic [QW-1:0] w1_r  [QW];
  logic [QW-1:0] w2_r  [QW];
  logic [DW-1:0] d_r   [QW];
  logic [SW-1:0] s_r   [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r1_in, r2_in, d_in;
    logic [QW-1:0] w1_in, w2_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   rs1, rs2;
    logic          ge1, ge2;

    // The first stage loads the high numerator bits as partial remainder.
    if (i == 0) begin : g_first
      assign v_in  = in_vld;
      assign r1_in = DW'(n1 >> QW);
      assign r2_in = DW'(n2 >> QW);
      assign w1_in = n1[QW-1:0];
      assign w2_in = n2[QW-1:0];
      assign d_in  = d;
      assign s_in  = side_i;
    end else begin : g_next
      assign v_in  = vld_r[i-1];
      assign r1_in = r1_r[i-1];
      assign r2_in = r2_r[i-1];
      assign w1_in = w1_r[i-1];
      assign w2_in = w2_r[i-1];
      assign d_in  = d_r[i-1];
      assign s_in  = s_r[i-1];
    end

    // Shift in the next numerator bit and try one subtraction.
    assign rs1 = {r1_in, w1_in[QW-1]};
    assign rs2 = {r2_in, w2_in[QW-1]};
    assign ge1 = rs1 >= {1'b0, d_in};
    assign ge2 = rs2 >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r1_r[i] <= ge1 ? DW'(rs1 - {1'b0, d_in}) : rs1[DW-1:0];
        r2_r[i] <= ge2 ? DW'(rs2 - {1'b0, d_in}) : rs2[DW-1:0];
        w1_r[i] <= {w1_in[QW-2:0], ge1};
        w2_r[i] <= {w2_in[QW-2:0], ge2};
        d_r[i]  <= d_in;
        s_r[i]  <= s_in;
      end
    end
  end

  assign out_vld = vld_r[QW-1];
  assign q1      = w1_r[QW-1];
  assign q2      = w2_r[QW-1];
  assign side_o  = s_r[QW-1];

endmodule

@@ rtl/svpwm_duty_calculator.sv @@
// Space-vector PWM duty calculator.
// The in_cmd channel takes one alpha/beta voltage command per item; the
// out_duty channel gives the three timer compare values and the sector code
// for that command, one result item per input item, in order.
// The cfg port writes time_gain, period_ticks, timer_period and the duty cap;
// write it only while no item is in flight.
// Between acceptance and out_duty.valid, five stages form the
// projections, active times and overmodulation numerators, an 18-stage
// divider scales the active times, and two stages build and clamp the
// compare values. Throughput is one item per cycle while the receiver does not stall.
// The whole pipeline advances together while the output register is empty
// or being taken. When the receiver stalls, every stage holds and in_cmd.ready
// drops, so nothing is lost or repeated.
// Reset clears all valid bits, holds in_cmd.ready low and loads the register
// defaults.
module svpwm_duty_calculator (
  input  logic         clk,
  input  logic         rst_n,
  svpwm_cmd_if.sink    in_cmd,
  svpwm_duty_if.source out_duty,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [31:0]  cfg_data
);

  localparam int MW  = svpwm_pkg::MW;
  localparam int UW  = svpwm_pkg::UW;
  localparam int TW  = svpwm_pkg::TW;
  localparam int SUW = svpwm_pkg::SUW;
  localparam int LW  = svpwm_pkg::LW;
  localparam int NW  = svpwm_pkg::NW;
  localparam int ONW = svpwm_pkg::ONW;
  localparam int SW  = 1 + 3 + 2 * LW;

  // Configuration registers.
  logic [31:0] time_gain_r;
  logic [15:0] period_ticks_r, timer_period_r, duty_cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_gain_r    <= svpwm_pkg::TIME_GAIN_RST;
      period_ticks_r <= svpwm_pkg::PERIOD_TICKS_RST;
      timer_period_r <= svpwm_pkg::TIMER_PERIOD_RST;
      duty_cap_r     <= svpwm_pkg::DUTY_CAP_RST;
    end else if (cfg_we) begin
      case (svpwm_pkg::reg_idx_t'(cfg_idx))
        svpwm_pkg::REG_TIME_GAIN:    time_gain_r    <= cfg_data;
        svpwm_pkg::REG_PERIOD_TICKS: period_ticks_r <= cfg_data[15:0];
        svpwm_pkg::REG_TIMER_PERIOD: timer_period_r <= cfg_data[15:0];
        svpwm_pkg::REG_DUTY_CAP:     duty_cap_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0] lim;
  assign lim = {period_ticks_r, 2'b00};

  // Global pipeline enable.
  logic en;
  assign en           = !out_duty.valid || out_duty.ready;
  assign in_cmd.ready = en && rst_n;

  // Stage 1: sqrt3 * alpha.
  logic                 s1_vld_r;
  logic signed [UW-1:0] s1_x_r;
  logic signed [15:0]   s1_vb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r  <= UW'($signed({1'b0, svpwm_pkg::SQRT3_Q16}) * in_cmd.v_alpha);
      s1_vb_r <= in_cmd.v_beta;
    end
  end

  // Stage 2: projections, sector code and active-time operands.
  logic signed [UW-1:0] ua, ub, uc, vb16, p1_s, p2_s;
  logic [2:0]           sec;

  assign ua   = UW'(s1_vb_r) <<< 17;
  assign vb16 = UW'(s1_vb_r) <<< 16;
  assign ub   = s1_x_r - vb16;
  assign uc   = -s1_x_r - vb16;
  assign sec  = {uc > 0, ub > 0, ua > 0};

  always_comb begin
    p1_s = '0;
    p2_s = '0;
    case (sec)
      svpwm_pkg::SECTOR_1: begin p1_s = -ub; p2_s = -uc; end
      svpwm_pkg::SECTOR_2: begin p1_s = -uc; p2_s = -ua; end
      svpwm_pkg::SECTOR_3: begin p1_s = ub;  p2_s = ua;  end
      svpwm_pkg::SECTOR_4: begin p1_s = -ua; p2_s = -ub; end
      svpwm_pkg::SECTOR_5: begin p1_s = ua;  p2_s = uc;  end
      svpwm_pkg::SECTOR_6: begin p1_s = uc;  p2_s = ub;  end
      default: ;
    endcase
  end

  logic          s2_vld_r;
  logic [2:0]    s2_sec_r;
  logic [MW-1:0] s2_m1_r, s2_m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sec_r <= sec;
      s2_m1_r  <= (p1_s > 0) ? p1_s[MW-1:0] : '0;
      s2_m2_r  <= (p2_s > 0) ? p2_s[MW-1:0] : '0;
    end
  end

  // Stage 3: gain products, integer and fraction halves.
  logic             s3_vld_r;
  logic [2:0]       s3_sec_r;
  logic [MW+15:0]   s3_h1_r, s3_l1_r, s3_h2_r, s3_l2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sec_r <= s2_sec_r;
      s3_h1_r  <= s2_m1_r * time_gain_r[31:16];
      s3_l1_r  <= s2_m1_r * time_gain_r[15:0];
      s3_h2_r  <= s2_m2_r * time_gain_r[31:16];
      s3_l2_r  <= s2_m2_r * time_gain_r[15:0];
    end
  end

  // Stage 4: active times in quarter ticks.
  logic [MW+16:0] acc1, acc2;
  assign acc1 = {1'b0, s3_h1_r} + {17'd0, s3_l1_r[MW+15:16]};
  assign acc2 = {1'b0, s3_h2_r} + {17'd0, s3_l2_r[MW+15:16]};

  logic          s4_vld_r;
  logic [2:0]    s4_sec_r;
  logic [TW-1:0] s4_t1_r, s4_t2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sec_r <= s3_sec_r;
      s4_t1_r  <= TW'(acc1 >> 23);
      s4_t2_r  <= TW'(acc2 >> 23);
    end
  end

  // Stage 5: overmodulation test and divider numerators.
  logic [SUW-1:0] sum;
  assign sum = {1'b0, s4_t1_r} + {1'b0, s4_t2_r};

  logic           s5_vld_r, s5_over_r;
  logic [2:0]     s5_sec_r;
  logic [SUW-1:0] s5_sum_r;
  logic [NW-1:0]  s5_n1_r, s5_n2_r;
  logic [LW-1:0]  s5_t1_r, s5_t2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sec_r  <= s4_sec_r;
      s5_sum_r  <= sum;
      s5_over_r <= sum > SUW'(lim);
      s5_n1_r   <= s4_t1_r * lim;
      s5_n2_r   <= s4_t2_r * lim;
      s5_t1_r   <= s4_t1_r[LW-1:0];
      s5_t2_r   <= s4_t2_r[LW-1:0];
    end
  end

  // Scale both active times by lim / sum.
  logic          dv_vld;
  logic [LW-1:0] dv_q1, dv_q2;
  logic [SW-1:0] dv_side;

  svpwm_div #(
    .NW(NW),
    .DW(SUW),
    .QW(LW),
    .SW(SW)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (s5_vld_r),
    .n1     (s5_n1_r),
    .n2     (s5_n2_r),
    .d      (s5_sum_r),
    .side_i ({s5_over_r, s5_sec_r, s5_t1_r, s5_t2_r}),
    .out_vld(dv_vld),
    .q1     (dv_q1),
    .q2     (dv_q2),
    .side_o (dv_side)
  );

  logic          dv_over;
  logic [2:0]    dv_sec;
  logic [LW-1:0] t1f, t2f, t0;
  assign dv_over = dv_side[SW-1];
  assign dv_sec  = dv_side[SW-2:SW-4];
  assign t1f     = dv_over ? dv_q1 : dv_side[2*LW-1:LW];
  assign t2f     = dv_over ? dv_q2 : dv_side[LW-1:0];
  assign t0      = lim - t1f - t2f;

  // Stage F1: on-times assigned to phases by sector.
  logic [ONW-1:0] on_f, on_s, on_t, on_a, on_b, on_c;
  assign on_f = ONW'(t0);
  assign on_s = on_f + ONW'({t1f, 1'b0});
  assign on_t = on_s + ONW'({t2f, 1'b0});

  always_comb begin
    case (dv_sec)
      svpwm_pkg::SECTOR_1: begin on_b = on_f; on_a = on_s; on_c = on_t; end
      svpwm_pkg::SECTOR_2: begin on_a = on_f; on_c = on_s; on_b = on_t; end
      svpwm_pkg::SECTOR_4: begin on_c = on_f; on_b = on_s; on_a = on_t; end
      svpwm_pkg::SECTOR_5: begin on_b = on_f; on_c = on_s; on_a = on_t; end
      svpwm_pkg::SECTOR_6: begin on_c = on_f; on_a = on_s; on_b = on_t; end
      default:             begin on_a = on_f; on_b = on_s; on_c = on_t; end
    endcase
  end

  logic           f1_vld_r, f1_zero_r;
  logic [2:0]     f1_sec_r;
  logic [ONW-1:0] f1_on_a_r, f1_on_b_r, f1_on_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_sec_r  <= dv_sec;
      f1_zero_r <= (t1f == '0) && (t2f == '0);
      f1_on_a_r <= on_a;
      f1_on_b_r <= on_b;
      f1_on_c_r <= on_c;
    end
  end

  // Stage F2: subtract from the timer period and clamp.
  function automatic logic [15:0] clamp_duty(input logic [15:0] tp,
                                             input logic [15:0] mx,
                                             input logic [ONW-1:0] on);
    logic signed [16:0] dv;
    dv = $signed({1'b0, tp}) - $signed({1'b0, 16'(on >> 4)});
    if (dv < 0) begin
      return '0;
    end else if (dv[15:0] > mx) begin
      return mx;
    end
    return dv[15:0];
  endfunction

  logic        out_vld_r;
  logic [15:0] duty_a_r, duty_b_r, duty_c_r;
  logic [2:0]  sector_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sector_r <= f1_sec_r;
      duty_a_r <= f1_zero_r ? '0 : clamp_duty(timer_period_r, duty_cap_r, f1_on_a_r);
      duty_b_r <= f1_zero_r ? '0 : clamp_duty(timer_period_r, duty_cap_r, f1_on_b_r);
      duty_c_r <= f1_zero_r ? '0 : clamp_duty(timer_period_r, duty_cap_r, f1_on_c_r);
    end
  end

  assign out_duty.valid  = out_vld_r;
  assign out_duty.duty_a = duty_a_r;
  assign out_duty.duty_b = duty_b_r;
  assign out_duty.duty_c = duty_c_r;
  assign out_duty.sector = sector_r;

  // Conditions watched by the checks below.
  logic out_zero_vec, out_stall;
  assign out_zero_vec = out_vld_r && (sector_r == svpwm_pkg::SECTOR_0);
  assign out_stall    = out_vld_r && !out_duty.ready;

`include "assert_macros.svh"

  // A zero vector never drives any phase.
  `SVPWM_ASSERT(a_zero_vec, !out_zero_vec || ({duty_a_r, duty_b_r, duty_c_r} == '0), "zero vector duty")
  // All three signs positive cannot come out of the projections.
  `SVPWM_ASSERT(a_no_sec7, !(s2_vld_r && s2_sec_r == svpwm_pkg::SECTOR_7), "impossible sector code")
  // A stalled result is still there in the next cycle.
  `SVPWM_ASSERT_NEXT(a_stall_hold, out_stall, out_vld_r && $stable(sector_r), "stalled result lost")

endmodule
